FILE: design/pneumatic_glove_p_controller_assert.svh
// assertion macros shared by the checker
`ifndef PNEUMATIC_GLOVE_P_CONTROLLER_ASSERT_SVH
`define PNEUMATIC_GLOVE_P_CONTROLLER_ASSERT_SVH

// same-cycle implication, off during reset
`define PGPC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pgpc same-cycle check failed");

// next-cycle implication, off during reset
`define PGPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pgpc next-cycle check failed");

// what must follow a reset cycle
`define PGPC_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("pgpc reset check failed");

`endif

FILE: design/pgpc_pkg.sv
`timescale 1ns / 1ps

package pgpc_pkg;

   localparam int ANGLE_W         = 12;
   localparam int DEADBAND_W      = 10;
   localparam int GAIN_W          = 16;
   localparam int PWM_W           = 8;
   localparam int MODE_W          = 2;
   localparam int FLAG_W          = 2;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 16;
   localparam int FINGERS_DEFAULT = 5;
   // 1/16 degree angles times a Q8.8 gain
   localparam int SCALE_SHIFT     = 12;

   typedef enum logic [MODE_W-1:0] {
      MODE_STOP     = 2'd0,
      MODE_PRESSURE = 2'd1,
      MODE_VACUUM   = 2'd2,
      MODE_HOLD     = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_ANGLE   = 3'd0,
      CSR_DEADBAND       = 3'd1,
      CSR_KP_PRESSURE    = 3'd2,
      CSR_KP_VACUUM      = 3'd3,
      CSR_FLOOR_PRESSURE = 3'd4,
      CSR_FLOOR_VACUUM   = 3'd5,
      CSR_MAX_PWM        = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]    target_angle;
      logic [DEADBAND_W-1:0] deadband;
      logic [GAIN_W-1:0]     kp_pressure;
      logic [GAIN_W-1:0]     kp_vacuum;
      logic [PWM_W-1:0]      floor_pressure;
      logic [PWM_W-1:0]      floor_vacuum;
      logic [PWM_W-1:0]      max_pwm;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      target_angle:   12'd0,
      deadband:       10'd32,
      kp_pressure:    16'd256,
      kp_vacuum:      16'd256,
      floor_pressure: 8'd0,
      floor_vacuum:   8'd0,
      max_pwm:        8'd255
   };

   typedef struct packed {
      mode_type mode;
      logic     settled;
   } stage_ctl_type;

   function automatic int sum_w(input int fingers);
      return $clog2(fingers * ((1 << ANGLE_W) - 1) + 1);
   endfunction

   function automatic int prod_w(input int fingers);
      return GAIN_W + sum_w(fingers);
   endfunction

   function automatic int req_data_w(input int fingers);
      return ((FLAG_W + fingers * ANGLE_W + 7) / 8) * 8;
   endfunction

   function automatic int rsp_data_w(input int fingers);
      return ((MODE_W + 2 * PWM_W + fingers + 7) / 8) * 8;
   endfunction

endpackage

FILE: design/pneumatic_glove_p_controller.sv
`timescale 1ns / 1ps
// pipeline: an accepted item passes through the input register, the gain
// product register and the result register, in that order
// throughput: one item per cycle; each stage moves when the next one is free
// reset (synchronous): all stage valid flags clear, config registers take defaults
// target 0, deadband 32, gains 256, min pwm 0, max pwm 255

module pneumatic_glove_p_controller
   import pgpc_pkg::*;
#(
   parameter int FINGERS = FINGERS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // running, valves_settled, finger_angle_0 .. finger_angle_N, zero pad
   input  logic [req_data_w(FINGERS)-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // mode, pressure_pump_pwm, vacuum_pump_pwm, valve_open_mask, zero pad
   output logic [rsp_data_w(FINGERS)-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [CSR_IDX_W-1:0]              csr_addr,
   input  logic [CSR_DATA_W-1:0]             csr_wdata
);

   localparam int PROD_W = prod_w(FINGERS);
   localparam int RSP_W  = rsp_data_w(FINGERS);

   cfg_type cfg;

   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   logic                            s1_running_ff;
   logic                            s1_settled_ff;
   logic [FINGERS-1:0][ANGLE_W-1:0] s1_angle_ff;
   logic [FINGERS-1:0][ANGLE_W-1:0] angle_in;

   stage_ctl_type      ctl;
   logic [FINGERS-1:0] mask;
   logic [PROD_W-1:0]  product;

   logic               s2_valid_ff;
   logic               s2_valid_in;
   stage_ctl_type      s2_ctl_ff;
   logic [FINGERS-1:0] s2_mask_ff;
   logic [PROD_W-1:0]  s2_prod_ff;

   logic [PWM_W-1:0] ppwm;
   logic [PWM_W-1:0] vpwm;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff;
   logic [RSP_W-1:0] rsp_data_in;

   logic s2_ready;
   logic s3_ready;

   pgpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // each stage takes a new item when it is empty or its item moves on
   assign s3_ready   = !rsp_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign req_tready = !s1_valid_ff || s2_ready;

   assign s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
   assign s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = s3_ready ? s2_valid_ff : rsp_valid_ff;

   always_comb begin
      for (int i = 0; i < FINGERS; i++) begin
         angle_in[i] = req_tdata[FLAG_W + i*ANGLE_W +: ANGLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_running_ff <= req_tdata[0];
         s1_settled_ff <= req_tdata[1];
         s1_angle_ff   <= angle_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_ctl_ff  <= ctl;
         s2_mask_ff <= mask;
         s2_prod_ff <= product;
      end
      if (s3_ready && s2_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   pgpc_error #(
      .FINGERS (FINGERS)
   ) u_error (
      .cfg     (cfg),
      .running (s1_running_ff),
      .settled (s1_settled_ff),
      .angle   (s1_angle_ff),
      .ctl     (ctl),
      .mask    (mask),
      .product (product)
   );

   pgpc_pump #(
      .FINGERS (FINGERS)
   ) u_pump (
      .cfg               (cfg),
      .ctl               (s2_ctl_ff),
      .product           (s2_prod_ff),
      .pressure_pump_pwm (ppwm),
      .vacuum_pump_pwm   (vpwm)
   );

   assign rsp_data_in = RSP_W'({s2_mask_ff, vpwm, ppwm, s2_ctl_ff.mode});

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: design/pgpc_csr.sv
`timescale 1ns / 1ps

module pgpc_csr
   import pgpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_TARGET_ANGLE:   cfg_in.target_angle   = csr_wdata[ANGLE_W-1:0];
            CSR_DEADBAND:       cfg_in.deadband       = csr_wdata[DEADBAND_W-1:0];
            CSR_KP_PRESSURE:    cfg_in.kp_pressure    = csr_wdata[GAIN_W-1:0];
            CSR_KP_VACUUM:      cfg_in.kp_vacuum      = csr_wdata[GAIN_W-1:0];
            CSR_FLOOR_PRESSURE: cfg_in.floor_pressure = csr_wdata[PWM_W-1:0];
            CSR_FLOOR_VACUUM:   cfg_in.floor_vacuum   = csr_wdata[PWM_W-1:0];
            CSR_MAX_PWM:        cfg_in.max_pwm        = csr_wdata[PWM_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/pgpc_error.sv
`timescale 1ns / 1ps

module pgpc_error
   import pgpc_pkg::*;
#(
   parameter int FINGERS = FINGERS_DEFAULT
) (
   input  cfg_type                            cfg,
   input  logic                               running,
   input  logic                               settled,
   input  logic [FINGERS-1:0][ANGLE_W-1:0]    angle,
   output stage_ctl_type                      ctl,
   output logic [FINGERS-1:0]                 mask,
   output logic [prod_w(FINGERS)-1:0]         product
);

   localparam int SUM_W  = sum_w(FINGERS);
   localparam int PROD_W = prod_w(FINGERS);

   logic [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]  tgt_scaled;
   logic [SUM_W-1:0]  band;
   logic [SUM_W-1:0]  mag;
   logic [GAIN_W-1:0] kp;
   logic              pressure;
   logic              vacuum;

   always_comb begin
      sum = '0;
      for (int i = 0; i < FINGERS; i++) begin
         sum = sum + SUM_W'(angle[i]);
      end
   end

   // error and band are both scaled by the finger count
   assign tgt_scaled = SUM_W'(cfg.target_angle) * SUM_W'(FINGERS);
   assign band       = SUM_W'(cfg.deadband) * SUM_W'(FINGERS);

   assign pressure = {1'b0, tgt_scaled} > ({1'b0, sum} + {1'b0, band});
   assign vacuum   = {1'b0, sum} > ({1'b0, tgt_scaled} + {1'b0, band});

   assign mag     = pressure ? (tgt_scaled - sum) : (sum - tgt_scaled);
   assign kp      = vacuum ? cfg.kp_vacuum : cfg.kp_pressure;
   assign product = PROD_W'(kp) * PROD_W'(mag);

   always_comb begin
      ctl.settled = settled;
      ctl.mode    = MODE_HOLD;
      mask        = '0;
      if (!running) begin
         ctl.mode = MODE_STOP;
      end else if (pressure) begin
         ctl.mode = MODE_PRESSURE;
         // angle below target minus deadband, no valve when that goes negative
         for (int i = 0; i < FINGERS; i++) begin
            mask[i] = ({1'b0, angle[i]} + (ANGLE_W+1)'(cfg.deadband))
                      < {1'b0, cfg.target_angle};
         end
      end else if (vacuum) begin
         ctl.mode = MODE_VACUUM;
         mask     = '1;
      end
   end

endmodule

FILE: design/pgpc_pump.sv
`timescale 1ns / 1ps

module pgpc_pump
   import pgpc_pkg::*;
#(
   parameter int FINGERS = FINGERS_DEFAULT
) (
   input  cfg_type                    cfg,
   input  stage_ctl_type              ctl,
   input  logic [prod_w(FINGERS)-1:0] product,
   output logic [PWM_W-1:0]           pressure_pump_pwm,
   output logic [PWM_W-1:0]           vacuum_pump_pwm
);

   localparam int PROD_W    = prod_w(FINGERS);
   localparam int NUM_W     = PROD_W + 1;
   localparam int V_W       = NUM_W - SCALE_SHIFT;
   localparam int SAT_CMD   = 1 << PWM_W;
   localparam int SAT_LIMIT = SAT_CMD * FINGERS;
   localparam int VS_W      = $clog2(SAT_LIMIT);
   localparam int HALF      = FINGERS << (SCALE_SHIFT - 1);
   localparam int RCP_SHIFT = $clog2(SAT_LIMIT * FINGERS);
   localparam int RCP_W     = RCP_SHIFT + 1;
   localparam int RCP       = ((1 << RCP_SHIFT) + FINGERS - 1) / FINGERS;
   localparam int QP_W      = VS_W + RCP_W;

   logic [NUM_W-1:0] num;
   logic [V_W-1:0]   scaled;
   logic             sat;
   logic [VS_W-1:0]  low;
   logic [QP_W-1:0]  qprod;
   logic [PWM_W:0]   cmd_raw;
   logic [PWM_W:0]   cmd_min;
   logic [PWM_W-1:0] min_pwm;
   logic [PWM_W-1:0] cmd;

   // round half up, then split the divide into a shift and a finger-count divide
   assign num    = NUM_W'(product) + NUM_W'(HALF);
   assign scaled = num[NUM_W-1:SCALE_SHIFT];

   // anything at or past full scale clamps anyway, so only a short value is divided
   assign sat   = scaled >= V_W'(SAT_LIMIT);
   assign low   = scaled[VS_W-1:0];
   assign qprod = QP_W'(low) * QP_W'(RCP);

   assign cmd_raw = sat ? (PWM_W+1)'(SAT_CMD) : {1'b0, qprod[RCP_SHIFT +: PWM_W]};

   assign min_pwm = (ctl.mode == MODE_VACUUM) ? cfg.floor_vacuum : cfg.floor_pressure;

   assign cmd_min = ((cmd_raw != '0) && (cmd_raw < {1'b0, min_pwm})) ? {1'b0, min_pwm}
                                                                      : cmd_raw;
   assign cmd     = (cmd_min > {1'b0, cfg.max_pwm}) ? cfg.max_pwm : cmd_min[PWM_W-1:0];

   assign pressure_pump_pwm = ((ctl.mode == MODE_PRESSURE) && ctl.settled) ? cmd : '0;
   assign vacuum_pump_pwm   = ((ctl.mode == MODE_VACUUM) && ctl.settled) ? cmd : '0;

endmodule

FILE: design/pgpc_checker.sv
`timescale 1ns / 1ps
`include "pneumatic_glove_p_controller_assert.svh"

module pgpc_checker
   import pgpc_pkg::*;
#(
   parameter int FINGERS = FINGERS_DEFAULT
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rsp_data_w(FINGERS)-1:0] rsp_tdata
);

   localparam int RSP_W    = rsp_data_w(FINGERS);
   localparam int PPWM_LSB = MODE_W;
   localparam int VPWM_LSB = MODE_W + PWM_W;
   localparam int MASK_LSB = MODE_W + 2 * PWM_W;

   mode_type           rsp_mode;
   logic [PWM_W-1:0]   rsp_ppwm;
   logic [PWM_W-1:0]   rsp_vpwm;
   logic [FINGERS-1:0] rsp_mask;
   logic               stalled;
   logic               idle_out;
   logic               vac_out;
   logic               prs_out;

   assign rsp_mode = mode_type'(rsp_tdata[MODE_W-1:0]);
   assign rsp_ppwm = rsp_tdata[PPWM_LSB +: PWM_W];
   assign rsp_vpwm = rsp_tdata[VPWM_LSB +: PWM_W];
   assign rsp_mask = rsp_tdata[MASK_LSB +: FINGERS];

   assign stalled  = rsp_tvalid && !rsp_tready;
   assign idle_out = rsp_tvalid && (rsp_mode == MODE_STOP || rsp_mode == MODE_HOLD);
   assign vac_out  = rsp_tvalid && rsp_mode == MODE_VACUUM;
   assign prs_out  = rsp_tvalid && rsp_mode == MODE_PRESSURE;

   `PGPC_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, !rsp_tvalid)

   `PGPC_ASSERT_NEXT(a_stall_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_tdata))

   // stop and hold drive pumps off and valves closed
   `PGPC_ASSERT_NOW(a_idle_zero, clock, reset, idle_out, rsp_tdata[RSP_W-1:MODE_W] == '0)

   `PGPC_ASSERT_NOW(a_vacuum_valves, clock, reset, vac_out, rsp_mask == '1 && rsp_ppwm == '0)

   `PGPC_ASSERT_NOW(a_pressure_only, clock, reset, prs_out, rsp_vpwm == '0)

endmodule

bind pneumatic_glove_p_controller pgpc_checker #(
   .FINGERS (FINGERS)
) u_pgpc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: verif/pneumatic_glove_p_controller_tb.sv
`timescale 1ns / 1ps

module pneumatic_glove_p_controller_tb;
   import pgpc_pkg::*;

   localparam int FINGERS    = FINGERS_DEFAULT;
   localparam int REQ_W      = req_data_w(FINGERS);
   localparam int RSP_W      = rsp_data_w(FINGERS);
   localparam int ANG_BITS   = FINGERS * ANGLE_W;
   localparam int LATENCY    = 3;
   localparam int QUIET_MAX  = 1000;
   localparam int PHASES     = 10;
   localparam int PHASE_LEN  = 150;
   localparam longint PUMP_DEN = longint'(FINGERS) << SCALE_SHIFT;
   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      mode_type           mode;
      logic [PWM_W-1:0]   ppwm;
      logic [PWM_W-1:0]   vpwm;
      logic [FINGERS-1:0] mask;
   } drive_type;

   typedef enum logic {ROW_CSR, ROW_TICK} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      int                    value;
      logic                  run;
      logic                  settled;
      logic [ANG_BITS-1:0]   angles;
      logic                  typed;
      drive_type             want;
   } step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cfg_type   model_cfg = CFG_RESET;
   drive_type pending_drive[$];
   step_type  script[$];
   int        mismatch_count = 0;
   int        results_seen = 0;
   int        ticks_sent = 0;
   int        settings_used = 0;
   int        mode_hits[4] = '{0, 0, 0, 0};
   int        rsp_hold = 0;
   int        quiet_cycles = 0;
   bit        gaps_on = 1'b1;
   bit        stalls_on = 1'b1;

   pneumatic_glove_p_controller #(.FINGERS(FINGERS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic drive_type drive(input mode_type m, input int p, input int v,
                                       input int k);
      drive_type r;
      r.mode = m;
      r.ppwm = p[PWM_W-1:0];
      r.vpwm = v[PWM_W-1:0];
      r.mask = k[FINGERS-1:0];
      return r;
   endfunction

   function automatic logic [PWM_W-1:0] pump_level(input int mag, input int kp,
                                                   input int floor_pwm);
      longint cmd;
      cmd = (longint'(kp) * mag + PUMP_DEN / 2) / PUMP_DEN;
      if (cmd > 0 && cmd < floor_pwm) cmd = floor_pwm;
      // max clamp goes last, so it beats the minimum
      if (cmd > int'(model_cfg.max_pwm)) cmd = int'(model_cfg.max_pwm);
      return cmd[PWM_W-1:0];
   endfunction

   function automatic drive_type compute_drive(input logic run, input logic settled,
                                               input logic [ANG_BITS-1:0] angles);
      drive_type r;
      int sum;
      int err;
      int band;
      int open_below;
      r = drive(MODE_STOP, 0, 0, 0);
      if (run) begin
         sum = 0;
         for (int i = 0; i < FINGERS; i++) sum += int'(angles[i*ANGLE_W +: ANGLE_W]);
         err = FINGERS * int'(model_cfg.target_angle) - sum;
         band = FINGERS * int'(model_cfg.deadband);
         open_below = int'(model_cfg.target_angle) - int'(model_cfg.deadband);
         if (err > band) begin
            r.mode = MODE_PRESSURE;
            for (int i = 0; i < FINGERS; i++)
               if (int'(angles[i*ANGLE_W +: ANGLE_W]) < open_below) r.mask[i] = 1'b1;
            if (settled)
               r.ppwm = pump_level(err, model_cfg.kp_pressure, model_cfg.floor_pressure);
         end else if (-err > band) begin
            r.mode = MODE_VACUUM;
            r.mask = '1;
            if (settled)
               r.vpwm = pump_level(-err, model_cfg.kp_vacuum, model_cfg.floor_vacuum);
         end else begin
            r.mode = MODE_HOLD;
         end
      end
      return r;
   endfunction

   function automatic logic [ANG_BITS-1:0] pack_angles(input int a0, input int a1,
                                                      input int a2, input int a3,
                                                      input int a4);
      logic [ANG_BITS-1:0] v;
      v = {a4[ANGLE_W-1:0], a3[ANGLE_W-1:0], a2[ANGLE_W-1:0], a1[ANGLE_W-1:0],
           a0[ANGLE_W-1:0]};
      return v;
   endfunction

   function automatic step_type csr_row(input logic [CSR_IDX_W-1:0] idx, input int value);
      step_type s;
      s = '{ROW_CSR, idx, value, 1'b0, 1'b0, '0, 1'b0, drive(MODE_STOP, 0, 0, 0)};
      return s;
   endfunction

   function automatic step_type tick_row(input logic run, input logic settled,
                                         input logic [ANG_BITS-1:0] angles);
      step_type s;
      s = '{ROW_TICK, '0, 0, run, settled, angles, 1'b0, drive(MODE_STOP, 0, 0, 0)};
      return s;
   endfunction

   function automatic step_type typed_row(input logic run, input logic settled,
                                          input logic [ANG_BITS-1:0] angles,
                                          input drive_type want);
      step_type s;
      s = tick_row(run, settled, angles);
      s.typed = 1'b1;
      s.want = want;
      return s;
   endfunction

   function automatic int pick(input int hi);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return hi;
         2, 3: return $urandom_range(0, hi / 16);
         default: return $urandom_range(0, hi);
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input int want, input int got);
      $display("%0t ns: %s expected %0d got %0d", $realtime, what, want, got);
      mismatch_count++;
   endtask

   task automatic send_tick(input logic run, input logic settled,
                            input logic [ANG_BITS-1:0] angles, input drive_type want);
      int gap;
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_W - ANG_BITS - FLAG_W){1'b0}}, angles, settled, run};
      do @(posedge clock); while (!req_tready);
      pending_drive.push_back(want);
      ticks_sent++;
   endtask

   // registers change only with the pipeline empty
   task automatic quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TARGET_ANGLE:   model_cfg.target_angle = value[ANGLE_W-1:0];
         CSR_DEADBAND:       model_cfg.deadband = value[DEADBAND_W-1:0];
         CSR_KP_PRESSURE:    model_cfg.kp_pressure = value[GAIN_W-1:0];
         CSR_KP_VACUUM:      model_cfg.kp_vacuum = value[GAIN_W-1:0];
         CSR_FLOOR_PRESSURE: model_cfg.floor_pressure = value[PWM_W-1:0];
         CSR_FLOOR_VACUUM:   model_cfg.floor_vacuum = value[PWM_W-1:0];
         CSR_MAX_PWM:        model_cfg.max_pwm = value[PWM_W-1:0];
         default: ;
      endcase
   endtask

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      drive_type got;
      drive_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.mode = mode_type'(rsp_tdata[MODE_W-1:0]);
         got.ppwm = rsp_tdata[MODE_W +: PWM_W];
         got.vpwm = rsp_tdata[MODE_W+PWM_W +: PWM_W];
         got.mask = rsp_tdata[MODE_W+2*PWM_W +: FINGERS];
         if (pending_drive.size() == 0) begin
            flag_mismatch("unexpected item, mode", -1, got.mode);
         end else begin
            want = pending_drive.pop_front();
            if (got.mode != want.mode) flag_mismatch("mode", want.mode, got.mode);
            if (got.ppwm != want.ppwm) flag_mismatch("pressure pwm", want.ppwm, got.ppwm);
            if (got.vpwm != want.vpwm) flag_mismatch("vacuum pwm", want.vpwm, got.vpwm);
            if (got.mask != want.mask) flag_mismatch("valve mask", want.mask, got.mask);
         end
         results_seen++;
         mode_hits[got.mode]++;
         rsp_hold = stalls_on ? $urandom_range(0, 5) : 0;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
         $display("pneumatic_glove_p_controller: mismatch");
         $finish;
      end
   end

   initial begin
      step_type            s;
      drive_type           want;
      logic                run;
      logic                settled;
      logic [ANG_BITS-1:0] angles;
      int                  spread;
      int                  a;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      script.push_back(typed_row(1'b0, 1'b1, pack_angles(4095, 4095, 4095, 4095, 4095),
                                 drive(MODE_STOP, 0, 0, 0)));
      script.push_back(typed_row(1'b1, 1'b1, pack_angles(0, 0, 0, 0, 0),
                                 drive(MODE_HOLD, 0, 0, 0)));
      script.push_back(typed_row(1'b1, 1'b1, pack_angles(4095, 4095, 4095, 4095, 4095),
                                 drive(MODE_VACUUM, 0, 255, 'h1f)));
      script.push_back(typed_row(1'b1, 1'b0, pack_angles(4095, 4095, 4095, 4095, 4095),
                                 drive(MODE_VACUUM, 0, 0, 'h1f)));
      // error right on the deadband edge holds, one more count draws vacuum
      script.push_back(typed_row(1'b1, 1'b1, pack_angles(32, 32, 32, 32, 32),
                                 drive(MODE_HOLD, 0, 0, 0)));
      script.push_back(tick_row(1'b1, 1'b1, pack_angles(33, 32, 32, 32, 32)));
      script.push_back(csr_row(CSR_TARGET_ANGLE, 4095));
      script.push_back(typed_row(1'b1, 1'b1, pack_angles(0, 0, 0, 0, 0),
                                 drive(MODE_PRESSURE, 255, 0, 'h1f)));
      script.push_back(typed_row(1'b1, 1'b0, pack_angles(0, 0, 0, 0, 0),
                                 drive(MODE_PRESSURE, 0, 0, 'h1f)));
      script.push_back(csr_row(CSR_DEADBAND, 1023));
      script.push_back(tick_row(1'b1, 1'b1, pack_angles(4095, 0, 0, 0, 0)));
      // per-finger valve threshold, just past the band
      script.push_back(tick_row(1'b1, 1'b1, pack_angles(3072, 3071, 3072, 3071, 3072)));
      script.push_back(csr_row(CSR_KP_PRESSURE, 0));
      script.push_back(typed_row(1'b1, 1'b1, pack_angles(0, 0, 0, 0, 0),
                                 drive(MODE_PRESSURE, 0, 0, 'h1f)));
      script.push_back(csr_row(CSR_DEADBAND, 0));
      script.push_back(csr_row(CSR_KP_PRESSURE, 1));
      script.push_back(csr_row(CSR_FLOOR_PRESSURE, 200));
      script.push_back(tick_row(1'b1, 1'b1, pack_angles(4094, 4095, 4095, 4095, 4095)));
      // exact half count rounds up to one, then lifted to the minimum
      script.push_back(tick_row(1'b1, 1'b1, pack_angles(2047, 2047, 2047, 2047, 2047)));
      script.push_back(csr_row(CSR_MAX_PWM, 100));
      script.push_back(typed_row(1'b1, 1'b1, pack_angles(2047, 2047, 2047, 2047, 2047),
                                 drive(MODE_PRESSURE, 100, 0, 'h1f)));
      script.push_back(csr_row(CSR_MAX_PWM, 0));
      script.push_back(typed_row(1'b1, 1'b1, pack_angles(2047, 2047, 2047, 2047, 2047),
                                 drive(MODE_PRESSURE, 0, 0, 'h1f)));
      script.push_back(csr_row(CSR_TARGET_ANGLE, 0));
      script.push_back(csr_row(CSR_KP_VACUUM, 65535));
      script.push_back(csr_row(CSR_FLOOR_VACUUM, 255));
      script.push_back(csr_row(CSR_MAX_PWM, 255));
      script.push_back(tick_row(1'b1, 1'b1, pack_angles(0, 0, 0, 0, 1)));
      script.push_back(typed_row(1'b1, 1'b1, pack_angles(0, 0, 0, 0, 0),
                                 drive(MODE_HOLD, 0, 0, 0)));
      script.push_back(csr_row(CSR_UNMAPPED, 'hffff));
      script.push_back(tick_row(1'b1, 1'b1, pack_angles(0, 0, 0, 0, 1)));
      script.push_back(tick_row(1'b1, 1'b1, pack_angles('haaa, 'h555, 'haaa, 'h555, 'haaa)));
      script.push_back(tick_row(1'b1, 1'b0, pack_angles('h555, 'haaa, 'h555, 'haaa, 'h555)));

      settings_used = 1;
      foreach (script[i]) begin
         s = script[i];
         if (s.kind == ROW_CSR) begin
            quiesce();
            write_register(s.idx, s.value);
            settings_used++;
         end else begin
            want = s.typed ? s.want : compute_drive(s.run, s.settled, s.angles);
            send_tick(s.run, s.settled, s.angles, want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         quiesce();
         gaps_on = (p != 0) && ($urandom_range(0, 3) != 0);
         stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
         write_register(CSR_TARGET_ANGLE, pick(4095));
         write_register(CSR_DEADBAND, pick(1023));
         write_register(CSR_KP_PRESSURE, pick(65535));
         write_register(CSR_KP_VACUUM, pick(65535));
         write_register(CSR_FLOOR_PRESSURE, pick(255));
         write_register(CSR_FLOOR_VACUUM, pick(255));
         write_register(CSR_MAX_PWM, ($urandom_range(0, 3) == 0) ? pick(255) : 255);
         if ($urandom_range(0, 3) == 0) write_register(CSR_UNMAPPED, $urandom_range(0, 65535));
         settings_used++;
         for (int n = 0; n < PHASE_LEN; n++) begin
            run = ($urandom_range(0, 9) != 0);
            settled = ($urandom_range(0, 3) != 0);
            spread = int'(model_cfg.deadband) + $urandom_range(1, 200);
            if ($urandom_range(0, 2) == 0) begin
               angles = ANG_BITS'({$urandom, $urandom});
            end else begin
               // cluster around the setpoint so all three modes show up
               for (int f = 0; f < FINGERS; f++) begin
                  a = int'(model_cfg.target_angle) + $urandom_range(0, 2 * spread) - spread;
                  if (a < 0) a = 0;
                  if (a > 4095) a = 4095;
                  angles[f*ANGLE_W +: ANGLE_W] = a[ANGLE_W-1:0];
               end
            end
            send_tick(run, settled, angles, compute_drive(run, settled, angles));
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (LATENCY * 4) @(posedge clock);

      $display("%0d control ticks under %0d register settings, %0d results compared",
               ticks_sent, settings_used, results_seen);
      $display("modes seen: stop %0d, pressure %0d, vacuum %0d, hold %0d",
               mode_hits[MODE_STOP], mode_hits[MODE_PRESSURE], mode_hits[MODE_VACUUM],
               mode_hits[MODE_HOLD]);
      if (mismatch_count == 0 && pending_drive.size() == 0) begin
         $display("pneumatic_glove_p_controller: match");
      end else begin
         $display("pneumatic_glove_p_controller: mismatch");
      end
      $finish;
   end

endmodule
